FILE: rtl/qebd_pkg.sv
// Shared types and constants for the quadrature encoder and button decoder.
`timescale 1ns / 1ps

package qebd_pkg;

	// Command codes carried by each input word
	typedef enum logic [2:0] {
		CMD_UPDATE     = 3'd0,
		CMD_RESYNC     = 3'd1,
		CMD_READ_STEPS = 3'd2,
		CMD_READ_CLICK = 3'd3,
		CMD_READ_HOLD  = 3'd4
	} cmd_t;

	localparam logic [15:0] HOLD_MS_RST   = 16'd500;
	localparam logic [1:0]  PHASE_IDLE    = 2'b11;
	localparam logic signed [15:0] STEP_MAX = 16'sh7FFF;
	localparam logic signed [15:0] STEP_MIN = 16'sh8000;

	// One input word after registering
	typedef struct packed {
		logic [2:0]  cmd;
		logic        phase_a;
		logic        phase_b;
		logic        switch_level;
		logic [31:0] now_ms;
	} item_t;

	// One result word
	typedef struct packed {
		logic signed [15:0] steps;
		logic               click;
		logic               hold;
	} result_t;

endpackage

FILE: rtl/qebd_core.sv
// Decoder state and the combinational update applied to each registered input word.
`timescale 1ns / 1ps

module qebd_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  qebd_pkg::item_t  item,
	input  logic [15:0]      hold_ms,
	output qebd_pkg::result_t result
);
	import qebd_pkg::*;

	logic [1:0]         prev_phase_q, prev_phase_d;
	logic               prev_pressed_q, prev_pressed_d;
	logic signed [15:0] step_count_q, step_count_d, step_next;
	logic [31:0]        press_start_q, press_start_d;
	logic               hold_done_q, hold_done_d;
	logic               click_q, click_d, click_next;
	logic               hold_q, hold_d, hold_next;
	logic [1:0]         phase;
	logic               pressed;
	logic               fwd;
	logic [31:0]        elapsed;
	cmd_t               cmd;

	assign phase   = {item.phase_a, item.phase_b};
	assign pressed = ~item.switch_level;
	assign cmd     = cmd_t'(item.cmd);

	// Forward Gray sequence 0 -> 1 -> 3 -> 2 -> 0
	always_comb begin
		case (prev_phase_q)
			2'd0: fwd = (phase == 2'd1);
			2'd1: fwd = (phase == 2'd3);
			2'd3: fwd = (phase == 2'd2);
			default: fwd = (phase == 2'd0);
		endcase
	end

	// Work out state after the command, then the clears done by reads
	always_comb begin
		prev_phase_d   = prev_phase_q;
		prev_pressed_d = prev_pressed_q;
		step_next      = step_count_q;
		press_start_d  = press_start_q;
		hold_done_d    = hold_done_q;
		click_next     = click_q;
		hold_next      = hold_q;
		elapsed        = 32'd0;
		case (cmd)
			CMD_UPDATE: begin
				// count the encoder step, saturating at the 16-bit limits
				if (phase != prev_phase_q) begin
					if (fwd) begin
						if (step_count_q != STEP_MAX) step_next = step_count_q + 16'sd1;
					end else begin
						if (step_count_q != STEP_MIN) step_next = step_count_q - 16'sd1;
					end
					prev_phase_d = phase;
				end
				// stamp a new press
				if (pressed && !prev_pressed_q) begin
					press_start_d = item.now_ms;
					hold_done_d   = 1'b0;
				end
				elapsed = item.now_ms - press_start_d;
				// long hold cancels any pending click
				if (pressed && !hold_done_d && (elapsed >= {16'd0, hold_ms})) begin
					hold_next   = 1'b1;
					hold_done_d = 1'b1;
					click_next  = 1'b0;
				end
				// short release sets the click
				if (!pressed && prev_pressed_q && !hold_done_d) click_next = 1'b1;
				prev_pressed_d = pressed;
			end
			CMD_RESYNC: begin
				prev_phase_d   = phase;
				prev_pressed_d = pressed;
			end
			default: begin
			end
		endcase

		step_count_d = step_next;
		click_d      = click_next;
		hold_d       = hold_next;
		case (cmd)
			CMD_READ_STEPS: step_count_d = 16'sd0;
			CMD_READ_CLICK: click_d      = 1'b0;
			CMD_READ_HOLD:  hold_d       = 1'b0;
			default: begin
			end
		endcase
	end

	assign result.steps = step_next;
	assign result.click = click_next;
	assign result.hold  = hold_next;

	// Hold state; advance only when a word is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_phase_q   <= PHASE_IDLE;
			prev_pressed_q <= 1'b0;
			step_count_q   <= 16'sd0;
			press_start_q  <= 32'd0;
			hold_done_q    <= 1'b0;
			click_q        <= 1'b0;
			hold_q         <= 1'b0;
		end else if (fire) begin
			prev_phase_q   <= prev_phase_d;
			prev_pressed_q <= prev_pressed_d;
			step_count_q   <= step_count_d;
			press_start_q  <= press_start_d;
			hold_done_q    <= hold_done_d;
			click_q        <= click_d;
			hold_q         <= hold_d;
		end
	end

endmodule

FILE: rtl/quadrature_encoder_button_decoder.sv
// Quadrature encoder and push-button decoder: input register, update core, result register.
`timescale 1ns / 1ps

// Each input word (command, encoder phases, switch level, millisecond time) passes
// through an input register, is applied to the decoder state combinationally, and leaves
// as one result word from the result register. A new word is taken in every cycle in
// which in_stall is low; the input register lets one word wait while a finished result
// is stalled at the output, so throughput is one word per cycle whenever the output is
// not stalled. Results report the step count and click/hold flags after the command acted
// and before the clear done by a read command. hold_ms may only be written while idle.
module quadrature_encoder_button_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         cmd,
	input  logic               phase_a,
	input  logic               phase_b,
	input  logic               switch_level,
	input  logic [31:0]        now_ms,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] steps,
	output logic               click,
	output logic               hold
);
	import qebd_pkg::*;

	logic [15:0] hold_ms_q;
	logic        valid_s1;
	item_t       item_s1;
	logic        valid_s2;
	result_t     result_s2;
	result_t     result;
	logic        out_free;
	logic        fire;
	logic        in_take;

	assign out_free = ~valid_s2 | ~out_stall;
	assign fire     = valid_s1 & out_free;
	assign in_stall = valid_s1 & ~out_free;
	assign in_take  = in_valid & ~in_stall;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ms_q <= HOLD_MS_RST;
		end else if (cfg_we) begin
			hold_ms_q <= cfg_wdata;
		end
	end

	// Input register: load when empty or when its word moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.cmd          <= cmd;
			item_s1.phase_a      <= phase_a;
			item_s1.phase_b      <= phase_b;
			item_s1.switch_level <= switch_level;
			item_s1.now_ms       <= now_ms;
		end
	end

	qebd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item    (item_s1),
		.hold_ms (hold_ms_q),
		.result  (result)
	);

	// Result register: hold while stalled, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign steps     = result_s2.steps;
	assign click     = result_s2.click;
	assign hold      = result_s2.hold;

endmodule
